// ===== rtl/steq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timer event queue package
// Shared types, codes and constants for the timer queue, its cells and ports.
// ----------------------------------------------------------------------------
`default_nettype none

package steq_pkg;

    // Default number of event slots in the cell chain.
    localparam int STEQ_DEPTH = 16;

    // Reset value of the counter frequency register.
    localparam logic [31:0] TPS_RESET = 32'd19200000;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_TPS = 1'b0;

    // Item mode codes.
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] delay_seconds;
        logic [7:0]  event_tag;
    } item_t;

    typedef struct packed {
        logic       fired;
        logic [7:0] fired_tag;
        logic       add_accepted;
        logic       add_rejected_full;
        logic [4:0] pending_count;
        logic       timer_armed;
    } result_t;

    // One stored event.
    typedef struct packed {
        logic [63:0] expiry;
        logic [7:0]  tag;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_INSERT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/steq_item_if.sv =====
// ----------------------------------------------------------------------------
// Timer queue item channel
// Valid/ready channel carrying add and tick items into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface steq_item_if import steq_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/steq_result_if.sv =====
// ----------------------------------------------------------------------------
// Timer queue result channel
// Valid/ready channel carrying one result transaction per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface steq_result_if import steq_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/steq_apb.sv =====
// ----------------------------------------------------------------------------
// Timer queue configuration port
// APB-style register slave holding the counter frequency register.
// ----------------------------------------------------------------------------
`default_nettype none

module steq_apb import steq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [31:0]           ticks_per_second
);

    logic [31:0] tps_reg;
    logic [31:0] tps_next;
    logic        reg_idx;

    // Registers are word aligned, so bit 2 selects the register.
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        tps_next = tps_reg;
        if (psel && penable && pwrite && (reg_idx == REG_IDX_TPS))
        begin
            tps_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else
        begin
            tps_reg <= tps_next;
        end
    end

    assign prdata           = (reg_idx == REG_IDX_TPS) ? tps_reg : '0;
    assign ticks_per_second = tps_reg;

endmodule

`default_nettype wire

// ===== rtl/steq_cell.sv =====
// ----------------------------------------------------------------------------
// Timer queue cell
// One slot of the sorted chain: keeps, shifts in from a neighbour, or loads
// the new event, and reports whether its expiry sorts at or before it.
// ----------------------------------------------------------------------------
`default_nettype none

module steq_cell import steq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire entry_t     new_entry,
    input  wire logic       prev_le,
    input  wire entry_t     prev_entry,
    input  wire entry_t     next_entry,
    output entry_t          entry,
    output logic            le
);

    entry_t entry_reg;
    entry_t entry_next;

    // An occupied slot whose expiry is not later than the new one stays put;
    // equal expiries therefore keep arrival order.
    assign le = occupied && (entry_reg.expiry <= new_entry.expiry);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.insert && !le)
        begin
            entry_next = prev_le ? new_entry : prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_timer_event_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted timer event queue
// A 64-bit tick count and a chain of cells holding pending events in
// expiry order; ticks pop due events, adds insert new ones in order.
// ----------------------------------------------------------------------------
// Timing: a tick transaction's result is registered on acceptance; an add
// transaction's result is registered in ST_INSERT, after the delay product.
// Throughput: one tick per cycle while results are taken; an add blocks input
// in ST_INSERT: the delay product is registered before the insertion compare.
// Reset: the count and pending total clear, ticks_per_second returns to
// 19200000; the cell contents are not cleared, as only occupied cells are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timer_event_queue import steq_pkg::*;
#(
    parameter int QUEUE_DEPTH = STEQ_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    steq_item_if.sink                  item,
    steq_result_if.source              result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // The pending total needs to hold the depth itself.
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    logic [31:0] ticks_per_second;

    // Control state.
    state_t           state_reg;
    state_t           state_next;
    logic [63:0]      now_reg;
    logic [63:0]      now_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             res_valid_reg;
    logic             res_valid_next;

    // Payload registers for an add in flight and for the waiting result.
    logic [63:0]      product_reg;
    logic [7:0]       tag_reg;
    result_t          res_reg;
    result_t          res_next;
    logic             res_load;

    logic             accept;
    logic [63:0]      now_plus1;
    logic             fire_due;
    logic             full;
    entry_t           new_entry;
    cell_ctrl_t       cell_ctrl;

    entry_t           cell_entry [QUEUE_DEPTH];
    logic             cell_le    [QUEUE_DEPTH];

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    steq_apb u_apb
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .ticks_per_second (ticks_per_second)
    );

    // ------------------------------------------------------------------------
    // Handshake. One item is worked on at a time. A result waiting in the
    // output register does not block a new item as long as it is being
    // taken in the same cycle; an add's result is loaded in ST_INSERT, when the
    // output register is guaranteed to be free.
    // ------------------------------------------------------------------------
    assign item.ready = (state_reg == ST_IDLE) && (!res_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;

    // The tick advances the count first, then the front cell is checked
    // against the advanced count.
    assign now_plus1 = now_reg + 64'd1;
    assign fire_due  = (count_reg != '0) && (cell_entry[0].expiry <= now_plus1);
    assign full      = (count_reg == FULL_COUNT);

    // The new event's expiry: the registered product plus the current count.
    // This sum feeds the compare inside every cell in the insertion cycle.
    assign new_entry.expiry = now_reg + product_reg;
    assign new_entry.tag    = tag_reg;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.data.mode == MODE_ADD))
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Outputs of the state machine: cell commands, count updates and the
    // result transaction.
    // ------------------------------------------------------------------------
    always_comb
    begin
        cell_ctrl  = '0;
        now_next   = now_reg;
        count_next = count_reg;
        res_load   = 1'b0;
        res_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.data.mode == MODE_TICK))
                begin
                    now_next = now_plus1;
                    res_load = 1'b1;
                    if (fire_due)
                    begin
                        cell_ctrl.pop      = 1'b1;
                        count_next         = count_reg - CNT_W'(1);
                        res_next.fired     = 1'b1;
                        res_next.fired_tag = cell_entry[0].tag;
                    end
                end
            end
            ST_INSERT:
            begin
                res_load = 1'b1;
                if (full)
                begin
                    res_next.add_rejected_full = 1'b1;
                end
                else
                begin
                    cell_ctrl.insert      = 1'b1;
                    count_next            = count_reg + CNT_W'(1);
                    res_next.add_accepted = 1'b1;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
        // The pending total is reported in five bits whatever the depth.
        res_next.pending_count = 5'(count_next);
        res_next.timer_armed   = (count_next != '0);
    end

    assign res_valid_next = res_load || (res_valid_reg && !result.ready);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // The delay product is a 32 by 32 multiply registered on acceptance.
    always_ff @(posedge clk)
    begin
        if (accept && (item.data.mode == MODE_ADD))
        begin
            product_reg <= {32'b0, item.data.delay_seconds} * {32'b0, ticks_per_second};
            tag_reg     <= item.data.event_tag;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    // ------------------------------------------------------------------------
    // Chain of cells. Cell 0 holds the earliest event. On insertion every
    // cell later than the new event's place takes its left neighbour's event;
    // on a pop every cell but the last takes its right neighbour's event.
    // ------------------------------------------------------------------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        logic   occupied;
        logic   prev_le;
        entry_t prev_entry;
        entry_t next_entry;

        assign occupied = (IDX < count_reg);

        if (i == 0)
        begin : g_first
            assign prev_le    = 1'b1;
            assign prev_entry = new_entry;
        end
        else
        begin : g_inner
            assign prev_le    = cell_le[i-1];
            assign prev_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_entry = cell_entry[i];
        end
        else
        begin : g_body
            assign next_entry = cell_entry[i+1];
        end

        steq_cell u_cell
        (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .occupied   (occupied),
            .new_entry  (new_entry),
            .prev_le    (prev_le),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .entry      (cell_entry[i]),
            .le         (cell_le[i])
        );
    end

endmodule

`default_nettype wire
